// ----- rtl/core/rxph_pkg.sv -----
`default_nettype none

package rxph_pkg;

    // Request kinds
    typedef enum logic [0:0] {
        REQ_BYTE  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_kind_t;

    // Packet status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED     = 2'd0,
        ST_BAD_LENGTH   = 2'd1,
        ST_XFER_OVERRUN = 2'd2,
        ST_BACKPRESSURE = 2'd3
    } pkt_status_t;

    localparam int unsigned MAX_PACKET    = 64;
    localparam int unsigned SEARCH_WINDOW = 32;
    localparam int unsigned HDR_LEN       = 6;
    localparam int unsigned POS_W         = 7;
    localparam int unsigned PROG_W        = 3;

    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_WIN  = POS_W'(SEARCH_WINDOW);
    localparam logic [6:0]        LEN_MAX  = 7'(MAX_PACKET);
    localparam logic [PROG_W-1:0] PROG_END = PROG_W'(HDR_LEN);

    // Page transfer header: 4B 03 03 1B 06 71
    function automatic logic [7:0] hdr_byte(input logic [PROG_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h4B;
            3'd1:    b = 8'h03;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h1B;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h71;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rx_packet_admit_header_sniff_core.sv -----
`default_nettype none

// Channel | handshake            | payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_ready  | req_type data_byte first_byte last_byte
//         |                      | packet_length pkt_short command_phase
//         |                      | ring_free ring_used
// out     | out_valid / out_ready| byte_out write_enable status_valid status
//         |                      | collecting_now transfer_done overflow_flag
//
// One request per cycle sustained while out_ready is high; each request's result appears in the cycle after
// it is accepted, held in the output register.
// The block state (flags, matcher, position) updates at acceptance, so a request
// right behind the previous one sees its effect with no bubble.
// in_ready is low only while a result sits unclaimed and out_ready is low.
// rst_n clears all block flags, the matcher and the output valid; payload and shown flags are not reset.

module rx_packet_admit_header_sniff_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 first_byte,
    input  wire logic                 last_byte,
    input  wire logic [6:0]           packet_length,
    input  wire logic                 pkt_short,
    input  wire logic                 command_phase,
    input  wire logic [11:0]          ring_free,
    input  wire logic [11:0]          ring_used,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                byte_out,
    output logic                      write_enable,
    output logic                      status_valid,
    output rxph_pkg::pkt_status_t     status,
    output logic                      collecting_now,
    output logic                      transfer_done,
    output logic                      overflow_flag
);
    import rxph_pkg::*;

    // Block state
    logic                collecting_reg,  collecting_next;
    logic                ready_flag_reg,  ready_flag_next;
    logic                overflowed_reg,  overflowed_next;
    logic [PROG_W-1:0]   prog_reg,        prog_next;
    logic [POS_W-1:0]    pos_reg,         pos_next;
    logic                seen_reg,        seen_next;
    logic                eligible_reg,    eligible_next;
    pkt_status_t         pstat_reg,       pstat_next;
    logic                in_pkt_reg,      in_pkt_next;

    // Result register
    logic                out_valid_reg;
    logic [7:0]          byte_reg,        byte_next;
    logic                we_reg,          we_next;
    logic                sv_reg,          sv_next;
    pkt_status_t         st_reg,          st_next;

    logic accept;

    // Per-byte working values
    logic                 len_bad;
    logic [PROG_W-1:0]    prog_cur;
    logic [PROG_W-1:0]    prog_adv;
    logic [POS_W-1:0]     pos_cur;
    logic                 seen_cur;
    logic                 in_pkt_cur;
    logic                 do_sniff;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign len_bad  = (packet_length == 7'd0) || (packet_length > LEN_MAX);

    always_comb
    begin
        collecting_next = collecting_reg;
        ready_flag_next = ready_flag_reg;
        overflowed_next = overflowed_reg;
        prog_next       = prog_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        eligible_next   = eligible_reg;
        pstat_next      = pstat_reg;
        in_pkt_next     = in_pkt_reg;
        byte_next       = 8'd0;
        we_next         = 1'b0;
        sv_next         = 1'b0;
        st_next         = ST_ACCEPTED;
        prog_cur        = '0;
        prog_adv        = '0;
        pos_cur         = pos_reg;
        seen_cur        = seen_reg;
        in_pkt_cur      = in_pkt_reg;
        do_sniff        = 1'b0;

        if (req_type == REQ_CLEAR) begin
            ready_flag_next = 1'b0;
            overflowed_next = 1'b0;
        end
        else begin
            byte_next = data_byte;

            // Packet start: status is decided once, here
            if (first_byte) begin
                pos_cur       = '0;
                prog_next     = '0;
                seen_cur      = 1'b0;
                in_pkt_cur    = 1'b1;
                eligible_next = 1'b0;
                if (len_bad) begin
                    pstat_next = ST_BAD_LENGTH;
                end
                else if (overflowed_reg) begin
                    pstat_next = ST_XFER_OVERRUN;
                end
                else if (ready_flag_reg) begin
                    pstat_next = ST_BACKPRESSURE;
                end
                else if ({5'd0, packet_length} > ring_free) begin
                    if (collecting_reg) begin
                        // ring overran mid-transfer: abort collection
                        collecting_next = 1'b0;
                        ready_flag_next = 1'b0;
                        overflowed_next = 1'b1;
                        pstat_next      = ST_XFER_OVERRUN;
                    end
                    else begin
                        pstat_next = ST_BACKPRESSURE;
                    end
                end
                else begin
                    pstat_next    = ST_ACCEPTED;
                    eligible_next = !collecting_reg && (ring_used == 12'd0) && command_phase;
                end
            end

            seen_next = seen_cur;
            pos_next  = pos_cur;

            if (in_pkt_cur) begin
                if (pstat_next == ST_ACCEPTED) begin
                    we_next  = 1'b1;
                    do_sniff = eligible_next && !seen_cur && (pos_cur < POS_WIN);
                end

                // Streaming header matcher, restarts on the lead byte
                if (do_sniff) begin
                    prog_cur = (prog_next >= PROG_END) ? '0 : prog_next;
                    if (data_byte == hdr_byte(prog_cur)) begin
                        prog_adv = prog_cur + PROG_W'(1);
                    end
                    else if (data_byte == hdr_byte('0)) begin
                        prog_adv = PROG_W'(1);
                    end
                    else begin
                        prog_adv = '0;
                    end
                    if (prog_adv == PROG_END) begin
                        seen_next = 1'b1;
                        prog_next = '0;
                    end
                    else begin
                        prog_next = prog_adv;
                    end
                end

                if (pos_cur != POS_MAX) begin
                    pos_next = pos_cur + POS_W'(1);
                end

                if (last_byte) begin
                    if (pstat_next == ST_ACCEPTED) begin
                        if (eligible_next && seen_next) begin
                            collecting_next = 1'b1;
                        end
                        // short packet closes the page transfer
                        if (collecting_next && pkt_short) begin
                            collecting_next = 1'b0;
                            ready_flag_next = 1'b1;
                        end
                    end
                    sv_next     = 1'b1;
                    st_next     = pstat_next;
                    in_pkt_cur  = 1'b0;
                end
            end
            else begin
                byte_next = data_byte;
            end
            in_pkt_next = in_pkt_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            collecting_reg <= 1'b0;
            ready_flag_reg <= 1'b0;
            overflowed_reg <= 1'b0;
            prog_reg       <= '0;
            pos_reg        <= '0;
            seen_reg       <= 1'b0;
            eligible_reg   <= 1'b0;
            pstat_reg      <= ST_ACCEPTED;
            in_pkt_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (accept) begin
                collecting_reg <= collecting_next;
                ready_flag_reg <= ready_flag_next;
                overflowed_reg <= overflowed_next;
                prog_reg       <= prog_next;
                pos_reg        <= pos_next;
                seen_reg       <= seen_next;
                eligible_reg   <= eligible_next;
                pstat_reg      <= pstat_next;
                in_pkt_reg     <= in_pkt_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Result payload, loaded with the request
    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg <= byte_next;
            we_reg   <= we_next;
            sv_reg   <= sv_next;
            st_reg   <= st_next;
        end
    end

    // Flags are shown as they stood after the request in the output register;
    // they only change on acceptance, which also refreshes the output register.
    logic coll_shown_reg, rdy_shown_reg, ovf_shown_reg;

    always_ff @(posedge clk)
    begin
        if (accept) begin
            coll_shown_reg <= collecting_next;
            rdy_shown_reg  <= ready_flag_next;
            ovf_shown_reg  <= overflowed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_out       = byte_reg;
    assign write_enable   = we_reg;
    assign status_valid   = sv_reg;
    assign status         = st_reg;
    assign collecting_now = coll_shown_reg;
    assign transfer_done  = rdy_shown_reg;
    assign overflow_flag  = ovf_shown_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rxph_checker.sv -----
`default_nettype none

module rxph_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [7:0]           byte_out,
    input wire logic                 write_enable,
    input wire logic                 status_valid,
    input wire rxph_pkg::pkt_status_t status,
    input wire logic                 collecting_now,
    input wire logic                 transfer_done
);
    import rxph_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status))
        else $error("result changed while stalled");

    // Only accepted packets are written
    a_we_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable && status_valid |-> status == ST_ACCEPTED)
        else $error("write enable on rejected packet");

    // Status reads zero off the last byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status_valid |-> status == ST_ACCEPTED)
        else $error("status set without status_valid");

    // A transfer is never both collecting and done
    a_coll_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(collecting_now && transfer_done))
        else $error("collecting and done together");

    // Free output slot means input is open
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind rx_packet_admit_header_sniff_core rxph_checker u_rxph_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_out       (byte_out),
    .write_enable   (write_enable),
    .status_valid   (status_valid),
    .status         (status),
    .collecting_now (collecting_now),
    .transfer_done  (transfer_done)
);

`default_nettype wire
